// File: rtl/core/phq_pkg.sv
// Package for the perfect-hash query engine: constants, sequencer states and the multiplier request type.
// No dependencies.
`default_nettype none
package phq_pkg;
    localparam int PilotDepth = 65536;
    localparam int PilotAw = $clog2(PilotDepth);
    localparam logic [63:0] K_FULL  = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] K_TAIL  = 64'h517cc1b727220a95;
    localparam logic [63:0] K_FINAL = 64'h94d049bb133111eb;
    localparam logic [63:0] K_SLOT  = 64'hbf58476d1ce4e5b9;

    localparam logic [1:0] REG_SEED  = 2'd0;
    localparam logic [1:0] REG_BCNT  = 2'd1;
    localparam logic [1:0] REG_RANGE = 2'd2;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_KEY   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_FIN1,
        ST_FIN2,
        ST_MOD1,
        ST_PREAD,
        ST_PWAIT,
        ST_SMUL,
        ST_MOD2,
        ST_OUT
    } state_t;

    // Unit op: one 32x32 partial product per cycle.
    typedef struct packed {
        logic start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;
endpackage
`default_nettype wire

// File: rtl/core/phq_fold_mul.sv
// Iterative fold multiply: hi ^ lo of a 64x64 product, one 32x32 partial per cycle.
// Depends on phq_pkg.
`default_nettype none
module phq_fold_mul (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire phq_pkg::mul_req_t req,
    output logic                  done,
    output logic [63:0]           result
);
    import phq_pkg::*;

    logic [63:0]  a_reg, b_reg;
    logic [127:0] acc_reg, acc_next;
    logic [2:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic [31:0]  xa, xb;
    logic [63:0]  pp;

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:
            begin
                xa = a_reg[31:0];  xb = b_reg[31:0];
            end
            2'd1:
            begin
                xa = a_reg[31:0];  xb = b_reg[63:32];
            end
            2'd2:
            begin
                xa = a_reg[63:32]; xb = b_reg[31:0];
            end
            default:
            begin
                xa = a_reg[63:32]; xb = b_reg[63:32];
            end
        endcase
        pp = xa * xb;
    end

    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done = !busy_reg && (cnt_reg == 3'd4);
        if (req.start)
        begin
            acc_next = '0;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            case (cnt_reg[1:0])
                2'd0:    acc_next = acc_reg + {64'd0, pp};
                2'd3:    acc_next = acc_reg + {pp, 64'd0};
                default: acc_next = acc_reg + {32'd0, pp, 32'd0};
            endcase
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg[1:0] == 2'd3)
                busy_next = 1'b0;
        end
        else if (cnt_reg == 3'd4)
        begin
            cnt_next = '0;
        end
    end

    assign result = acc_reg[127:64] ^ acc_reg[63:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (req.start)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/phq_mod.sv
// Restoring modulo unit: 64-bit dividend mod 33-bit divisor, one bit per cycle.
// No package dependency.
`default_nettype none
module phq_mod (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [32:0] divisor,
    output logic             done,
    output logic [32:0]      remainder
);
    logic [63:0] q_reg, q_next;
    logic [33:0] r_reg, r_next;
    logic [32:0] d_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [33:0] sh;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done = 1'b0;
        sh = {r_reg[32:0], q_reg[63]};
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next = {q_reg[62:0], 1'b0};
            r_next = (sh >= {1'b0, d_reg}) ? sh - {1'b0, d_reg} : sh;
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
            end
        end
        else if (cnt_reg == 7'd64)
        begin
            done = 1'b1;
            cnt_next = '0;
        end
    end

    assign remainder = r_reg[32:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
            d_reg <= divisor;
    end
endmodule
`default_nettype wire

// File: rtl/core/perfect_hash_query.sv
// Perfect-hash query engine top level. Uses phq_pkg, phq_fold_mul, phq_mod.
// A key chunk runs two fold multiplies on the shared 32x32 multiplier; a write
// request or an empty non-last chunk runs none. A last chunk then runs two finalize
// multiplies, the bucket modulo, the pilot read, one multiply and the slot modulo;
// with zero bytes it skips the key multiplies. Reset clears control state and the
// seed, and sets the bucket count and range registers to 1.
`default_nettype none
module perfect_hash_query (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: table_index[15:0], pilot_value[31:16], key_word[95:32],
    // key_bytes[99:96], zero pad to 104
    input  wire logic [103:0] s_axis_tdata,
    // tuser: action
    input  wire logic         s_axis_tuser,
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: slot_index
    output logic [31:0]       m_axis_tdata
);
    import phq_pkg::*;

    logic [63:0] seed_reg;
    logic [16:0] bcnt_reg;
    logic [31:0] range_reg;
    logic [15:0] pilot_mem [PilotDepth];
    logic [15:0] pilot_rd_reg;

    state_t      state_reg, state_next;
    logic [63:0] h1_reg, h1_next, h2_reg, h2_next, w_reg, w_next;
    logic [63:0] k_reg, k_next;
    logic        open_reg, open_next, last_reg, last_next, skip;
    logic [16:0] bucket_reg, bucket_next;
    logic [31:0] out_reg, out_next;
    logic        ovalid_reg, ovalid_next;

    mul_req_t    mreq;
    logic        mdone;
    logic [63:0] mres;
    logic        dstart, ddone;
    logic [63:0] ddiv;
    logic [32:0] dsor, drem;

    logic        wr_en;
    logic [1:0]  widx;
    logic [3:0]  nb;
    logic [63:0] mask, word_in;
    logic        accept;
    logic        out_free;

    phq_fold_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .done(mdone), .result(mres));
    phq_mod u_mod (.clk(clk), .rst_n(rst_n), .start(dstart), .dividend(ddiv),
                   .divisor(dsor), .done(ddone), .remainder(drem));

    assign pready = 1'b1;
    assign widx = paddr[4:3];
    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        case (widx)
            REG_SEED:  prdata = seed_reg;
            REG_BCNT:  prdata = {47'd0, bcnt_reg};
            REG_RANGE: prdata = {32'd0, range_reg};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            bcnt_reg <= 17'd1;
            range_reg <= 32'd1;
        end
        else if (wr_en)
        begin
            case (widx)
                REG_SEED:  seed_reg <= pwdata;
                REG_BCNT:  bcnt_reg <= pwdata[16:0];
                REG_RANGE: range_reg <= pwdata[31:0];
                default:   ;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = out_reg;
    assign out_free = !ovalid_reg || m_axis_tready;

    always_comb
    begin
        nb = s_axis_tdata[99:96];
        mask = '1;
        if (nb < 4'd8)
            mask = ~(64'hffff_ffff_ffff_ffff << {nb[2:0], 3'b000});
        word_in = s_axis_tdata[95:32] & mask;
        skip = (nb == 4'd0);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept && s_axis_tuser == ACT_KEY)
                    state_next = skip ? (s_axis_tlast ? ST_FIN1 : ST_IDLE) : ST_MUL1;
            ST_MUL1: if (mdone) state_next = ST_MUL2;
            ST_MUL2: if (mdone) state_next = last_reg ? ST_FIN1 : ST_IDLE;
            ST_FIN1: if (mdone) state_next = ST_FIN2;
            ST_FIN2: if (mdone) state_next = ST_MOD1;
            ST_MOD1: if (ddone) state_next = ST_PREAD;
            ST_PREAD: state_next = ST_PWAIT;
            ST_PWAIT: state_next = ST_SMUL;
            ST_SMUL: if (mdone) state_next = ST_MOD2;
            ST_MOD2: if (ddone) state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        h1_next = h1_reg;
        h2_next = h2_reg;
        w_next = w_reg;
        k_next = k_reg;
        open_next = open_reg;
        last_next = last_reg;
        bucket_next = bucket_reg;
        out_next = out_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        mreq = '{start: 1'b0, a: '0, b: '0};
        dstart = 1'b0;
        ddiv = '0;
        dsor = '0;
        case (state_reg)
            ST_IDLE:
                if (accept && s_axis_tuser == ACT_KEY)
                begin
                    if (!open_reg)
                    begin
                        h1_next = seed_reg;
                        h2_next = seed_reg ^ K_TAIL;
                    end
                    open_next = !s_axis_tlast;
                    last_next = s_axis_tlast;
                    w_next = word_in;
                    k_next = (nb >= 4'd8) ? K_FULL : K_TAIL;
                    if (!skip)
                        mreq = '{start: 1'b1, a: (open_reg ? h1_reg : seed_reg) ^ word_in,
                                 b: (nb >= 4'd8) ? K_FULL : K_TAIL};
                    else if (s_axis_tlast)
                        mreq = '{start: 1'b1, a: open_reg ? h1_reg : seed_reg, b: K_FINAL};
                end
            ST_MUL1:
                if (mdone)
                begin
                    h1_next = mres;
                    mreq = '{start: 1'b1, a: h2_reg ^ w_reg, b: k_reg};
                end
            ST_MUL2:
                if (mdone)
                begin
                    h2_next = mres;
                    if (last_reg)
                        mreq = '{start: 1'b1, a: h1_reg, b: K_FINAL};
                end
            ST_FIN1:
                if (mdone)
                begin
                    h1_next = mres;
                    mreq = '{start: 1'b1, a: h2_reg, b: K_FINAL};
                end
            ST_FIN2:
                if (mdone)
                begin
                    h2_next = mres;
                    dstart = 1'b1;
                    ddiv = h1_reg;
                    dsor = (bcnt_reg == '0) ? 33'd1 : {16'd0, bcnt_reg};
                end
            ST_MOD1:
                if (ddone)
                    bucket_next = drem[16:0];
            ST_PWAIT:
                mreq = '{start: 1'b1,
                         a: h2_reg ^ ((bucket_reg < 17'(PilotDepth))
                             ? {48'd0, pilot_rd_reg} * K_FULL : 64'd0),
                         b: K_SLOT};
            ST_SMUL:
                if (mdone)
                begin
                    dstart = 1'b1;
                    ddiv = mres;
                    dsor = (range_reg == '0) ? 33'd1 : {1'b0, range_reg};
                end
            ST_OUT:
                if (out_free)
                begin
                    out_next = drem[31:0];
                    ovalid_next = 1'b1;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            open_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            h1_reg <= '0;
            h2_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            open_reg <= open_next;
            ovalid_reg <= ovalid_next;
            h1_reg <= h1_next;
            h2_reg <= h2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        k_reg <= k_next;
        last_reg <= last_next;
        bucket_reg <= bucket_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && s_axis_tuser == ACT_WRITE)
            pilot_mem[s_axis_tdata[PilotAw-1:0]] <= s_axis_tdata[31:16];
        pilot_rd_reg <= pilot_mem[bucket_reg[PilotAw-1:0]];
    end
endmodule
`default_nettype wire
